[rtl/core/positional_list_store_assert.svh]
// Assertion macros used by the list store RTL.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define PLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define PLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pls_pkg.sv]
`default_nettype none

package pls_pkg;

    // Default sizing of the store
    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_WORD_BITS = 32;

    // Fixed field widths of the request and response beats
    localparam int OP_BITS       = 2;
    localparam int POSITION_BITS = 16;
    localparam int VALUE_BITS    = 32;
    localparam int OUT_WORD_BITS = 32;
    localparam int STATUS_BITS   = 2;
    localparam int LENGTH_BITS   = 7;

    // Request kinds
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_READ   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

    // Response status codes
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        [OP_BITS-1:0]       op;
        logic signed [POSITION_BITS-1:0] position;
        logic signed [VALUE_BITS-1:0]    value;
    } pls_req_t;

    typedef struct packed {
        logic signed [OUT_WORD_BITS-1:0] word_out;
        logic        [STATUS_BITS-1:0]   status;
        logic        [LENGTH_BITS-1:0]   length;
    } pls_rsp_t;

endpackage

`default_nettype wire

[rtl/core/pls_clamp.sv]
`default_nettype none

// Turn a signed position into a list index, clamped at both ends.
module pls_clamp
    import pls_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  wire logic signed [POSITION_BITS-1:0]      position,
    input  wire logic        [$clog2(CAPACITY+1)-1:0] count,
    input  wire logic                                 is_insert,
    output logic             [$clog2(CAPACITY)-1:0]   idx
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int SW = ((CW > POSITION_BITS) ? CW : POSITION_BITS) + 2;

    logic signed [SW-1:0] pos_s;
    logic signed [SW-1:0] cnt_s;
    logic signed [SW-1:0] base_s;
    logic signed [SW-1:0] limit_s;
    logic signed [SW-1:0] cand_s;
    logic signed [SW-1:0] res_s;

    // Extend both operands into one signed range
    assign pos_s = {{(SW-POSITION_BITS){position[POSITION_BITS-1]}}, position};
    assign cnt_s = {{(SW-CW){1'b0}}, count};

    // Insert may land one past the last word; access stops at the last word
    assign base_s  = is_insert ? (cnt_s + SW'(1)) : cnt_s;
    assign limit_s = is_insert ? cnt_s : (cnt_s - SW'(1));

    // Count back from the end for negative positions
    assign cand_s = position[POSITION_BITS-1] ? (base_s + pos_s) : pos_s;

    // Clamp at the front and at the end
    always_comb
    begin
        if (cand_s < SW'(0))
        begin
            res_s = '0;
        end
        else if (cand_s > limit_s)
        begin
            res_s = limit_s;
        end
        else
        begin
            res_s = cand_s;
        end
    end

    assign idx = res_s[IW-1:0];

endmodule

`default_nettype wire

[rtl/core/positional_list_store.sv]
`default_nettype none
// Ordered list store of up to CAPACITY words, addressed by a signed position.
// Request channel: drive req (op, position, value) with start high; the beat
// is taken at the rising edge where start is high and busy is low. busy then
// stays high until the response is issued.
// Response channel: done is high for exactly one cycle with rsp (word_out,
// status, length) valid in that cycle; the receiver cannot stall it. busy is
// already low in that cycle, so a new request may be taken at the same edge.
// Every request is checked in S_CALC, where a refused or no-op request ends;
// a read ends after its fetch in S_PICK. An insert, and a remove after S_PICK,
// alternate S_MOVE_RD and S_MOVE_WR for each word moved, then finish in
// S_MOVE_RD.
// Every word moved costs one read and one write on the single-ported word
// memory, stepped by one shared cursor adder and compare.
// Reset empties the list at once; memory contents are left as they are.
`include "positional_list_store_assert.svh"

module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire pls_req_t req,
    output logic          done,
    output pls_rsp_t      rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_CALC    = 5'b00010,
        S_PICK    = 5'b00100,
        S_MOVE_RD = 5'b01000,
        S_MOVE_WR = 5'b10000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         cursor_reg;
    logic [CW-1:0]         cursor_next;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         idx_next;
    logic [WORD_BITS-1:0]  word_reg;
    logic [WORD_BITS-1:0]  word_next;
    pls_req_t              req_reg;
    pls_rsp_t              rsp_reg;
    pls_rsp_t              rsp_next;
    logic                  done_reg;
    logic                  done_next;

    logic                  accept;
    logic [IW-1:0]         clamp_idx;
    logic [CW-1:0]         nb;
    logic                  step_go;
    logic                  is_insert;

    logic [WORD_BITS-1:0]  mem [CAPACITY];
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [WORD_BITS-1:0]  wr_data;

    logic [WORD_BITS+VALUE_BITS-1:0]    value_wide;
    logic [WORD_BITS-1:0]               value_word;
    logic [WORD_BITS-1:0]               fin_word;
    logic [OUT_WORD_BITS+WORD_BITS-1:0] fin_wide;
    logic [LENGTH_BITS+CW-1:0]          count_wide;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign is_insert = (req_reg.op == OP_INSERT);

    // Fit the incoming value to the stored word width
    assign value_wide = {{WORD_BITS{1'b0}}, req_reg.value};
    assign value_word = value_wide[WORD_BITS-1:0];

    pls_clamp #(
        .CAPACITY (CAPACITY)
    ) u_clamp (
        .position  (req_reg.position),
        .count     (count_reg),
        .is_insert (is_insert),
        .idx       (clamp_idx)
    );

    // Shared cursor unit: step towards the neighbour and test for more work
    assign nb      = is_insert ? (cursor_reg - CW'(1)) : (cursor_reg + CW'(1));
    assign step_go = is_insert ? (cursor_reg > CW'(idx_reg)) : (nb < count_reg);

    // Sequence one request through clamp, fetch and word moves
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        word_next   = word_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;
        fin_word    = '0;
        rd_en       = 1'b0;
        rd_addr     = cursor_reg[IW-1:0];
        wr_en       = 1'b0;
        wr_addr     = cursor_reg[IW-1:0];
        wr_data     = rd_data_reg;
        rsp_next.status = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CALC;
                end
            end

            S_CALC:
            begin
                case (req_reg.op)
                    OP_INSERT:
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            rsp_next.status = ST_FULL;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            idx_next    = clamp_idx;
                            cursor_next = count_reg;
                            state_next  = S_MOVE_RD;
                        end
                    end

                    OP_READ, OP_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_next.status = ST_EMPTY;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            rd_en       = 1'b1;
                            rd_addr     = clamp_idx;
                            idx_next    = clamp_idx;
                            cursor_next = CW'(clamp_idx);
                            state_next  = S_PICK;
                        end
                    end

                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end

            S_PICK:
            begin
                word_next = rd_data_reg;
                if (req_reg.op == OP_READ)
                begin
                    fin_word  = rd_data_reg;
                    done_next = 1'b1;
                end
                else
                begin
                    state_next = S_MOVE_RD;
                end
            end

            S_MOVE_RD:
            begin
                if (step_go)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = nb[IW-1:0];
                    state_next = S_MOVE_WR;
                end
                else if (is_insert)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg;
                    wr_data    = value_word;
                    count_next = count_reg + CW'(1);
                    done_next  = 1'b1;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    fin_word   = word_reg;
                    done_next  = 1'b1;
                end
            end

            S_MOVE_WR:
            begin
                wr_en       = 1'b1;
                cursor_next = nb;
                state_next  = S_MOVE_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Build the response beat on the finishing cycle
        fin_wide   = {{OUT_WORD_BITS{1'b0}}, fin_word};
        count_wide = {{LENGTH_BITS{1'b0}}, count_next};
        if (done_next)
        begin
            state_next        = S_IDLE;
            rsp_next.word_out = fin_wide[OUT_WORD_BITS-1:0];
            rsp_next.length   = count_wide[LENGTH_BITS-1:0];
        end
        else
        begin
            rsp_next.status = rsp_reg.status;
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Hold the request beat and working payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        cursor_reg <= cursor_next;
        idx_reg    <= idx_next;
        word_reg   <= word_next;
        rsp_reg    <= rsp_next;
    end

    // Word memory: one read or one write per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `PLS_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done longer than one cycle")
    `PLS_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "busy not raised after accept")
    `PLS_ASSERT_NOW(a_count_cap, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY), "count over capacity")
    `PLS_ASSERT_NOW(a_len_match, clk, rst_n, done, rsp.length == count_wide[LENGTH_BITS-1:0] || state_reg == S_IDLE, "length mismatch")
    `PLS_ASSERT_NOW(a_no_rw, clk, rst_n, rd_en, !wr_en, "read and write in one cycle")

endmodule

`default_nettype wire
